// ----- hdl/fir_filter_unit_assert.svh -----
// Assertion helpers included by the top-level RTL file, fir_filter_unit.sv.
`ifndef FIR_FILTER_UNIT_ASSERT_SVH
`define FIR_FILTER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge, with checking off during reset.
`define FFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FFU_ASSERT_NEXT(lbl, cond, expect_next, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ----- hdl/ffu_pkg.sv -----
`default_nettype none
package ffu_pkg;
    localparam int TAPS_DEF      = 8;
    localparam int SAMPLE_W_DEF  = 16;
    localparam int COEF_W        = 16;
    localparam int COEF_REGS     = 8;
    localparam int ROUND_SHIFT   = 15;
    localparam int CFG_IDX_W     = 8;

    typedef struct packed {
        logic                     en;
        logic signed [COEF_W-1:0] data;
    } t_coef_wr;
endpackage
`default_nettype wire

// ----- hdl/ffu_cell.sv -----
`default_nettype none
module ffu_cell
    import ffu_pkg::*;
#(
    parameter int SW       = SAMPLE_W_DEF,
    parameter int SUM_W    = SAMPLE_W_DEF + COEF_W + 3,
    parameter bit HAS_COEF = 1'b1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_shift,
    input  wire logic signed [SW-1:0]    i_sample_in,
    output logic signed [SW-1:0]         o_sample_out,
    input  wire t_coef_wr                i_coef_wr,
    input  wire logic signed [SUM_W-1:0] i_sum_in,
    output logic signed [SUM_W-1:0]      o_sum_out
);
    logic signed [SW-1:0]        r_sample;
    logic signed [COEF_W-1:0]    w_coef;
    logic signed [SW+COEF_W-1:0] r_prod;
    logic signed [SUM_W-1:0]     r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample_in;
        end
    end

    generate
        if (HAS_COEF) begin : g_coef
            logic signed [COEF_W-1:0] r_coef;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_coef <= '0;
                end else if (i_coef_wr.en) begin
                    r_coef <= i_coef_wr.data;
                end
            end
            assign w_coef = r_coef;
        end else begin : g_no_coef
            // taps past the register file have a fixed zero coefficient
            assign w_coef = '0;
        end
    endgenerate

    // product and partial sum run every cycle; the sum ripples one cell per clock
    always_ff @(posedge i_clk) begin
        r_prod <= r_sample * w_coef;
        r_sum  <= i_sum_in + SUM_W'(r_prod);
    end

    assign o_sample_out = r_sample;
    assign o_sum_out    = r_sum;
endmodule
`default_nettype wire

// ----- hdl/ffu_out.sv -----
`default_nettype none
module ffu_out
    import ffu_pkg::*;
#(
    parameter int SW    = SAMPLE_W_DEF,
    parameter int SUM_W = SAMPLE_W_DEF + COEF_W + 3
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire logic signed [SUM_W-1:0] i_sum,
    output logic                         o_can_load,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [SW-1:0]         o_data
);
    localparam int R_W = SUM_W + 1 - ROUND_SHIFT;

    logic [SUM_W:0]       w_biased;
    logic [R_W-1:0]       w_rs;
    logic [R_W-SW:0]      w_top;
    logic signed [SW-1:0] w_sat;
    logic                 r_valid;
    logic signed [SW-1:0] r_data;

    // round half up, then floor shift by taking the upper bits
    assign w_biased = {i_sum[SUM_W-1], i_sum} + (SUM_W+1)'(1 << (ROUND_SHIFT - 1));
    assign w_rs     = w_biased[SUM_W:ROUND_SHIFT];
    assign w_top    = w_rs[R_W-1:SW-1];

    always_comb begin
        if ((&w_top) || !(|w_top)) begin
            w_sat = w_rs[SW-1:0];
        end else if (w_rs[R_W-1]) begin
            w_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SW-1){1'b1}}};
        end
    end

    assign o_can_load = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= w_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ----- hdl/fir_filter_unit.sv -----
// Direct-form FIR filter built as a row of TAPS cells. Each cell holds one
// history sample and its Q1.15 coefficient; a new sample shifts into cell 0
// on acceptance, every cell forms its product, and the partial sum moves one
// cell per clock toward the end of the row. The result is rounded (add 2^14,
// shift right 15) and saturated to SW bits into an output register. One
// sample is processed at a time: o_sample_stall stays high while the sum
// ripples through the cell row and while a finished result cannot yet enter
// a still-occupied output register. The user must see that coefficients are
// written through the cfg port (index 0..7) only while no sample is in
// flight; the block itself does not enforce this. Taps past the eighth use a
// zero coefficient. Reset clears history and coefficients.
`default_nettype none
`include "fir_filter_unit_assert.svh"
module fir_filter_unit
    import ffu_pkg::*;
#(
    parameter int TAPS = TAPS_DEF,
    parameter int SW   = SAMPLE_W_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_sample_valid,
    output logic                      o_sample_stall,
    input  wire logic signed [SW-1:0] i_sample,
    output logic                      o_filtered_valid,
    input  wire logic                 i_filtered_stall,
    output logic signed [SW-1:0]      o_filtered,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COEF_W-1:0]    i_cfg_data
);
    localparam int SUM_W = SW + COEF_W + $clog2(TAPS) + 1;
    localparam int LAT   = TAPS + 1;
    localparam int CNT_W = $clog2(TAPS + 2);

    logic signed [SW-1:0]    w_smp [TAPS];
    logic signed [SUM_W-1:0] w_sum [TAPS];
    logic                    w_accept;
    logic                    w_cfg_wr;
    logic                    w_can_load;
    logic                    w_load;
    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        n_cnt;

    assign o_cfg_ready    = 1'b1;
    assign w_cfg_wr       = i_cfg_valid && o_cfg_ready;
    assign o_sample_stall = r_busy;
    assign w_accept       = i_sample_valid && !o_sample_stall;
    assign w_load         = r_busy && (r_cnt == CNT_W'(LAT)) && w_can_load;

    genvar k;
    generate
        for (k = 0; k < TAPS; k++) begin : g_cell
            t_coef_wr                w_wr;
            logic signed [SW-1:0]    w_in;
            logic signed [SUM_W-1:0] w_sin;

            assign w_wr.en   = w_cfg_wr && (k < COEF_REGS) && (i_cfg_index == CFG_IDX_W'(k));
            assign w_wr.data = i_cfg_data;
            if (k == 0) begin : g_head
                assign w_in  = i_sample;
                assign w_sin = '0;
            end else begin : g_link
                assign w_in  = w_smp[k-1];
                assign w_sin = w_sum[k-1];
            end

            ffu_cell #(
                .SW       (SW),
                .SUM_W    (SUM_W),
                .HAS_COEF (k < COEF_REGS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_shift      (w_accept),
                .i_sample_in  (w_in),
                .o_sample_out (w_smp[k]),
                .i_coef_wr    (w_wr),
                .i_sum_in     (w_sin),
                .o_sum_out    (w_sum[k])
            );
        end
    endgenerate

    always_comb begin
        n_cnt = r_cnt;
        if (w_accept) begin
            n_cnt = '0;
        end else if (r_busy && (r_cnt != CNT_W'(LAT))) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end
        end
    end

    ffu_out #(
        .SW    (SW),
        .SUM_W (SUM_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_sum      (w_sum[TAPS-1]),
        .o_can_load (w_can_load),
        .o_valid    (o_filtered_valid),
        .i_stall    (i_filtered_stall),
        .o_data     (o_filtered)
    );

    `FFU_ASSERT_NEXT(a_accept_starts, w_accept, r_busy && (r_cnt == '0), "accept did not start a run")
    `FFU_ASSERT(a_load_at_end, w_load |-> (r_cnt == CNT_W'(LAT)), "result loaded before sum settled")
    `FFU_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(LAT), "run counter out of range")
    `FFU_ASSERT(a_rose_after_load, $rose(o_filtered_valid) |-> $past(w_load), "result without a load")
endmodule
`default_nettype wire
